// ===== rtl/cmp_pkg.sv =====
// ----------------------------------------------------------------------------
// cmp_pkg
// Shared constants, payload types and sequencer states for the CUSUM
// change-point block.
// ----------------------------------------------------------------------------
`default_nettype none

package cmp_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int CNT_W  = $clog2(MAX_LEN + 1);        // sample count, holds MAX_LEN
  localparam int IDX_W  = $clog2(MAX_LEN);            // store address / split index
  localparam int PS_W   = SAMPLE_BITS + IDX_W + 1;    // prefix sum
  localparam int DIFF_W = PS_W + CNT_W;               // n*S_c - c*T
  localparam int MAG_W  = DIFF_W - 1;                 // |diff|
  localparam int SQ_W   = 2 * MAG_W;                  // |diff|^2
  localparam int FRAC_W = 16;                         // score fraction bits
  localparam int NUM_W  = SQ_W + FRAC_W;              // dividend
  localparam int Q_W    = 2 * CNT_W - 1;              // c*(n-c)
  localparam int DEN_W  = 3 * CNT_W;                  // n*c*(n-c)
  localparam int REM_W  = DEN_W + 1;
  localparam int SCORE_W = 2 * SAMPLE_BITS + CNT_W - 1 + FRAC_W - 2 + 2;
  localparam int ROOT_W = (SCORE_W + 1) / 2;
  localparam int CONTRAST_W = 28;
  localparam int STEP_W = $clog2(NUM_W + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic [CONTRAST_W-1:0] contrast;
    logic [IDX_W-1:0]      split_index;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_READ,
    ST_LATCH,
    ST_MUL,
    ST_DIFF,
    ST_SQ,
    ST_DIV,
    ST_DWAIT,
    ST_SQRT,
    ST_SWAIT,
    ST_OUT
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/cmp_ram.sv =====
// ----------------------------------------------------------------------------
// cmp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/cmp_div.sv =====
// ----------------------------------------------------------------------------
// cmp_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module cmp_div
  import cmp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]   den,
  output logic                    done,
  output logic      [SCORE_W-1:0] quo
);

  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt, rem_t;
  logic [REM_W-1:0]   den_r;
  logic [SCORE_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               run_r, run_nxt, done_r, done_nxt;
  logic               qbit;

  always_comb begin
    rem_t    = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
    qbit     = (rem_t >= den_r);
    rem_nxt  = qbit ? rem_t - den_r : rem_t;
    quo_nxt  = {quo_r[SCORE_W-2:0], qbit};
    num_nxt  = {num_r[NUM_W-2:0], 1'b0};
    cnt_nxt  = cnt_r + 1'b1;
    run_nxt  = run_r && (cnt_r != STEP_W'(NUM_W - 1));
    done_nxt = run_r && (cnt_r == STEP_W'(NUM_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      if (run_r) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= REM_W'(den);
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== rtl/cmp_sqrt.sv =====
// ----------------------------------------------------------------------------
// cmp_sqrt
// Integer square root, two radicand bits per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module cmp_sqrt
  import cmp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [SCORE_W-1:0]  x,
  output logic                     done,
  output logic      [ROOT_W-1:0]   root
);

  localparam int XW = 2 * ROOT_W;

  logic [XW-1:0]       x_r;
  logic [ROOT_W+1:0]   rem_r, rem_t, trial;
  logic [ROOT_W-1:0]   root_r;
  logic [STEP_W-1:0]   cnt_r;
  logic                run_r, done_r, take;

  always_comb begin
    rem_t = {rem_r[ROOT_W-1:0], x_r[XW-1:XW-2]};
    trial = {root_r, 2'b01};
    take  = (rem_t >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == STEP_W'(ROOT_W - 1));
      if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(ROOT_W - 1)) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= XW'(x);
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      x_r    <= {x_r[XW-3:0], 2'b00};
      rem_r  <= take ? rem_t - trial : rem_t;
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ===== rtl/cusum_mean_change_point.sv =====
// ----------------------------------------------------------------------------
// cusum_mean_change_point
// CUSUM change-in-mean statistic over one interval of samples: stores prefix
// sums, sweeps every split, reports sqrt of the best score and its index.
// ----------------------------------------------------------------------------
//  channel  | ports                        | transfer
//  ---------+------------------------------+---------------------------------
//  input    | start, busy, in_data         | start && !busy at clk edge
//  result   | out_valid, out_data          | one-cycle strobe, no back-pressure
//
//  Samples are taken one per cycle; busy stays low while an interval loads.
//  After the last sample each split c = 1..n-1 is scored in turn (serial
//  n-multiply, serial square, bit-serial divide); a final root follows, then
//  one result strobe.
//  Synchronous active-low reset clears count, total and sequencer.
//  The prefix-sum store has no reset: only entries written this interval are read.
// ----------------------------------------------------------------------------
`default_nettype none

module cusum_mean_change_point
  import cmp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data
);

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          cnt_r, n_r, c_r;
  logic signed [PS_W-1:0]    total_r;
  logic signed [PS_W-1:0]    sum_new;
  logic [CNT_W-1:0]          n_new;
  logic                      accept, room;

  logic signed [DIFF_W-1:0]  ct_r, ns_r, diff;
  logic signed [DIFF_W-1:0]  t_r;
  logic [Q_W-1:0]            q_r;
  logic signed [Q_W:0]       q_step;
  logic [DEN_W-1:0]          den_r;
  logic signed [PS_W-1:0]    s_r;
  logic [CNT_W-1:0]          nsh_r;
  logic [MAG_W-1:0]          mag_r, msh_r;
  logic [SQ_W-1:0]           sq_r;
  logic [STEP_W-1:0]         step_r;
  logic [SCORE_W-1:0]        best_r;
  logic [IDX_W-1:0]          split_r;
  logic [ROOT_W-1:0]         root_r;
  logic                      last_split;

  logic                      div_start, div_done, sqrt_start, sqrt_done;
  logic [SCORE_W-1:0]        quo;
  logic [ROOT_W-1:0]         root;
  logic [PS_W-1:0]           rd_data;

  assign accept  = start && !busy;
  assign room    = (cnt_r < CNT_W'(MAX_LEN));
  assign sum_new = total_r + PS_W'(in_data.sample);
  assign n_new   = room ? cnt_r + 1'b1 : cnt_r;
  assign diff    = ns_r - ct_r;
  assign last_split = (c_r + 1'b1 == n_r);
  // c(n-c) -> (c+1)(n-c-1) adds n - 2c - 1
  assign q_step  = $signed({2'b00, n_r}) - $signed({1'b0, c_r, 1'b0}) - 2'sb01;

  cmp_ram #(.WIDTH(PS_W), .DEPTH(MAX_LEN)) u_ram (
    .clk   (clk),
    .we    (accept && room),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (sum_new),
    .raddr (IDX_W'(c_r - 1'b1)),
    .rdata (rd_data)
  );

  cmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({sq_r, {FRAC_W{1'b0}}}),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  cmp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (best_r),
    .done  (sqrt_done),
    .root  (root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (accept && in_data.last_sample) begin
                  state_nxt = (n_new > CNT_W'(1)) ? ST_READ : ST_SQRT;
                end
      ST_READ:  state_nxt = ST_LATCH;
      ST_LATCH: state_nxt = ST_MUL;
      ST_MUL:   if (step_r == STEP_W'(CNT_W - 1)) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_SQ;
      ST_SQ:    if (step_r == STEP_W'(MAG_W - 1)) state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_DWAIT;
      ST_DWAIT: if (div_done) state_nxt = last_split ? ST_SQRT : ST_READ;
      ST_SQRT:  state_nxt = ST_SWAIT;
      ST_SWAIT: if (sqrt_done) state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    busy       = (state_r != ST_LOAD);
    div_start  = (state_r == ST_DIV);
    sqrt_start = (state_r == ST_SQRT);
    out_valid  = (state_r == ST_OUT);
    out_data.contrast    = root_r[CONTRAST_W-1:0];
    out_data.split_index = split_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_data.last_sample) begin
          cnt_r   <= '0;
          total_r <= '0;
        end else if (room) begin
          cnt_r   <= n_new;
          total_r <= sum_new;
        end
      end
    end
  end

  // total of the interval being swept; c*T steps by T per split
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && accept && in_data.last_sample) begin
      t_r <= DIFF_W'(room ? sum_new : total_r);
    end
  end

  // sweep datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: if (accept && in_data.last_sample) begin
        n_r     <= n_new;
        c_r     <= CNT_W'(1);
        ct_r    <= DIFF_W'(room ? sum_new : total_r);
        q_r     <= Q_W'(n_new - 1'b1);
        best_r  <= '0;
        split_r <= '0;
      end
      ST_LATCH: begin
        s_r    <= $signed(rd_data);
        nsh_r  <= n_r;
        ns_r   <= '0;
        den_r  <= '0;
        step_r <= '0;
      end
      ST_MUL: begin
        ns_r   <= (ns_r <<< 1) + (nsh_r[CNT_W-1] ? DIFF_W'(s_r) : '0);
        den_r  <= (den_r << 1) + (nsh_r[CNT_W-1] ? DEN_W'(q_r) : '0);
        nsh_r  <= {nsh_r[CNT_W-2:0], 1'b0};
        step_r <= step_r + 1'b1;
      end
      ST_DIFF: begin
        mag_r  <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        msh_r  <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        sq_r   <= '0;
        step_r <= '0;
      end
      ST_SQ: begin
        sq_r   <= (sq_r << 1) + (msh_r[MAG_W-1] ? SQ_W'(mag_r) : '0);
        msh_r  <= {msh_r[MAG_W-2:0], 1'b0};
        step_r <= step_r + 1'b1;
      end
      ST_DWAIT: if (div_done) begin
        if (quo > best_r) begin
          best_r  <= quo;
          split_r <= IDX_W'(c_r - 1'b1);
        end
        c_r  <= c_r + 1'b1;
        ct_r <= ct_r + t_r;
        q_r  <= Q_W'($signed({1'b0, q_r}) + q_step);
      end
      ST_SWAIT: if (sqrt_done) root_r <= root;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
